// ===== hw/rtl/bad_pkg.sv =====
// Package for the base attach detector: payload structs, register file type,
// request and register index codes, and a countdown helper. No dependencies.
package bad_pkg;

  localparam int TICK_COUNT_BITS = 10;
  localparam int CNT_MAX         = (1 << TICK_COUNT_BITS) - 1;

  localparam int MV_W   = 12;
  localparam int PCT_W  = 7;
  localparam int DLY_W  = 10;
  localparam int TEN_W  = 10;
  localparam int IDX_W  = 3;
  localparam int CFG_W  = 12;
  // Holds tenths + 5 and limit * 10 without overflow.
  localparam int CMP_W  = 11;

  typedef logic [TICK_COUNT_BITS-1:0] cnt_t;

  typedef enum logic [2:0] {
    REQ_TICK     = 3'd0,
    REQ_AC       = 3'd1,
    REQ_BATTERY  = 3'd2,
    REQ_STARTUP  = 3'd3,
    REQ_SHUTDOWN = 3'd4,
    REQ_F_ATTACH = 3'd5,
    REQ_F_DETACH = 3'd6,
    REQ_RESUME   = 3'd7
  } req_type_t;

  typedef enum logic [IDX_W-1:0] {
    REG_THR_NORMAL = 3'd0,
    REG_THR_LOW    = 3'd1,
    REG_BAT_LIMIT  = 3'd2,
    REG_INTERVAL   = 3'd3,
    REG_ATT_DEB    = 3'd4,
    REG_DET_DEB    = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic [2:0]       req_type;
    logic [MV_W-1:0]  sense_mv;
    logic [TEN_W-1:0] battery_tenths;
    logic             ac_present;
    logic             chipset_off;
  } bad_in_t;

  typedef struct packed {
    logic base_attached;
    logic slate_mode;
    logic low_power_switch;
    logic state_changed;
    logic detecting;
  } bad_out_t;

  typedef struct packed {
    logic [MV_W-1:0]  threshold_normal_mv;
    logic [MV_W-1:0]  threshold_low_mv;
    logic [PCT_W-1:0] battery_limit_pct;
    logic [DLY_W-1:0] sample_interval_ticks;
    logic [DLY_W-1:0] attach_debounce_ticks;
    logic [DLY_W-1:0] detach_debounce_ticks;
  } bad_cfg_t;

  // A delay of D ticks loads D-1 (zero stays zero), saturated to the counter.
  function automatic cnt_t delay_to_count(input logic [DLY_W-1:0] d);
    logic [31:0] c;
    c = (d != '0) ? (32'(d) - 32'd1) : 32'd0;
    if (c > 32'(CNT_MAX)) begin
      c = 32'(CNT_MAX);
    end
    return c[TICK_COUNT_BITS-1:0];
  endfunction

endpackage

// ===== hw/rtl/base_attach_detector_core.sv =====
// Each accepted request's result is registered in the result register or its skid entry.
// Throughput: one request per cycle while in_stall is low; the state update is a single pass of
// compare and select logic between the state registers and the result register.
// in_stall rises only when both the result register and its skid entry are full.
// Reset (rst_n low, synchronous): detached, detection on, countdown zero,
// switch off, configuration registers at their defaults, no results pending.
module base_attach_detector_core (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  bad_pkg::bad_in_t          in_data,
  output logic                      out_valid,
  input  logic                      out_stall,
  output bad_pkg::bad_out_t         out_data,
  input  logic                      cfg_we,
  input  logic [bad_pkg::IDX_W-1:0] cfg_idx,
  input  logic [bad_pkg::CFG_W-1:0] cfg_wdata
);
  import bad_pkg::*;

  bad_cfg_t cfg;
  bad_out_t result;
  logic     accept;
  logic     buf_full;

  assign in_stall = buf_full;
  assign accept   = in_valid && !buf_full;

  bad_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  bad_engine u_engine (
    .clk    (clk),
    .rst_n  (rst_n),
    .accept (accept),
    .req    (in_data),
    .cfg    (cfg),
    .result (result)
  );

  bad_outbuf u_outbuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (accept),
    .push_data (result),
    .full      (buf_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ===== hw/rtl/bad_cfg_regs.sv =====
// Configuration register file for the base attach detector.
// Depends on bad_pkg for the register struct and index codes.
module bad_cfg_regs (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_we,
  input  logic [bad_pkg::IDX_W-1:0] cfg_idx,
  input  logic [bad_pkg::CFG_W-1:0] cfg_wdata,
  output bad_pkg::bad_cfg_t       cfg
);
  import bad_pkg::*;

  bad_cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.threshold_normal_mv   <= MV_W'(2500);
      cfg_r.threshold_low_mv      <= MV_W'(1000);
      cfg_r.battery_limit_pct     <= PCT_W'(10);
      cfg_r.sample_interval_ticks <= DLY_W'(30);
      cfg_r.attach_debounce_ticks <= DLY_W'(300);
      cfg_r.detach_debounce_ticks <= DLY_W'(0);
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_idx))
        REG_THR_NORMAL: cfg_r.threshold_normal_mv   <= cfg_wdata[MV_W-1:0];
        REG_THR_LOW:    cfg_r.threshold_low_mv      <= cfg_wdata[MV_W-1:0];
        REG_BAT_LIMIT:  cfg_r.battery_limit_pct     <= cfg_wdata[PCT_W-1:0];
        REG_INTERVAL:   cfg_r.sample_interval_ticks <= cfg_wdata[DLY_W-1:0];
        REG_ATT_DEB:    cfg_r.attach_debounce_ticks <= cfg_wdata[DLY_W-1:0];
        REG_DET_DEB:    cfg_r.detach_debounce_ticks <= cfg_wdata[DLY_W-1:0];
        default: ;  // drop writes to unused indexes
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== hw/rtl/bad_engine.sv =====
// Detection state and per-request update: countdown, sampling with debounce,
// low-power switch and enable handling. Depends on bad_pkg.
module bad_engine (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               accept,
  input  bad_pkg::bad_in_t   req,
  input  bad_pkg::bad_cfg_t  cfg,
  output bad_pkg::bad_out_t  result
);
  import bad_pkg::*;

  logic attached_r, attached_nxt;
  logic deb_r, deb_nxt;
  logic det_r, det_nxt;
  cnt_t cnt_r, cnt_nxt;
  logic lp_r, lp_nxt;

  logic [CMP_W-1:0] tenths_rnd;
  logic [CMP_W-1:0] limit_x10;
  logic             lowbat;
  logic [MV_W-1:0]  thr;
  logic             above;
  logic [DLY_W-1:0] next_dly;

  // pct < limit  <=>  tenths + 5 < 10 * limit
  assign tenths_rnd = CMP_W'(req.battery_tenths) + CMP_W'(5);
  assign limit_x10  = (CMP_W'(cfg.battery_limit_pct) << 3)
                    + (CMP_W'(cfg.battery_limit_pct) << 1);
  assign lowbat     = (tenths_rnd < limit_x10) && !req.ac_present;
  assign thr        = lp_r ? cfg.threshold_low_mv : cfg.threshold_normal_mv;
  assign above      = req.sense_mv > thr;

  always_comb begin
    attached_nxt = attached_r;
    deb_nxt      = deb_r;
    det_nxt      = det_r;
    cnt_nxt      = cnt_r;
    lp_nxt       = lp_r;
    next_dly     = cfg.sample_interval_ticks;
    case (req_type_t'(req.req_type))
      REQ_TICK: begin
        if (det_r) begin
          if (cnt_r != '0) begin
            cnt_nxt = cnt_r - cnt_t'(1);
          end else begin
            if (above == attached_r) begin
              if (!deb_r) begin
                deb_nxt  = 1'b1;
                next_dly = above ? cfg.detach_debounce_ticks
                                 : cfg.attach_debounce_ticks;
              end else begin
                deb_nxt      = 1'b0;
                attached_nxt = !above;
                lp_nxt       = !above && lowbat;
              end
            end else begin
              deb_nxt = 1'b0;
            end
            cnt_nxt = delay_to_count(next_dly);
          end
        end
      end
      REQ_AC: begin
        if (req.chipset_off) begin
          if (req.ac_present) begin
            cnt_nxt = delay_to_count(cfg.sample_interval_ticks);
            det_nxt = 1'b1;
          end else begin
            det_nxt      = 1'b0;
            attached_nxt = 1'b0;
          end
        end
        lp_nxt = attached_nxt && !deb_r && lowbat;
      end
      REQ_BATTERY: begin
        lp_nxt = attached_r && !deb_r && lowbat;
      end
      REQ_STARTUP: begin
        cnt_nxt = delay_to_count(cfg.sample_interval_ticks);
        det_nxt = 1'b1;
        if (attached_r) begin
          lp_nxt = !deb_r && lowbat;
        end
      end
      REQ_SHUTDOWN: begin
        if (!req.ac_present) begin
          det_nxt      = 1'b0;
          attached_nxt = 1'b0;
          lp_nxt       = 1'b0;
        end
      end
      REQ_F_ATTACH: begin
        det_nxt      = 1'b0;
        attached_nxt = 1'b1;
        lp_nxt       = !deb_r && lowbat;
      end
      REQ_F_DETACH: begin
        det_nxt      = 1'b0;
        attached_nxt = 1'b0;
        lp_nxt       = 1'b0;
      end
      REQ_RESUME: begin
        cnt_nxt = delay_to_count(cfg.sample_interval_ticks);
        det_nxt = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      attached_r <= 1'b0;
      deb_r      <= 1'b0;
      det_r      <= 1'b1;
      cnt_r      <= '0;
      lp_r       <= 1'b0;
    end else if (accept) begin
      attached_r <= attached_nxt;
      deb_r      <= deb_nxt;
      det_r      <= det_nxt;
      cnt_r      <= cnt_nxt;
      lp_r       <= lp_nxt;
    end
  end

  always_comb begin
    result.base_attached    = attached_nxt;
    result.slate_mode       = !attached_nxt;
    result.low_power_switch = lp_nxt;
    result.state_changed    = attached_nxt != attached_r;
    result.detecting        = det_nxt;
  end

endmodule

// ===== hw/rtl/bad_outbuf.sv =====
// Result register with a skid entry, so a new request is taken while a
// result still waits downstream. Depends on bad_pkg for the result struct.
module bad_outbuf (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  bad_pkg::bad_out_t push_data,
  output logic              full,
  output logic              out_valid,
  input  logic              out_stall,
  output bad_pkg::bad_out_t out_data
);
  import bad_pkg::*;

  logic     main_vld_r;
  bad_out_t main_r;
  logic     skid_vld_r;
  bad_out_t skid_r;
  logic     main_free;

  assign main_free = !main_vld_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_vld_r <= 1'b0;
      skid_vld_r <= 1'b0;
    end else if (main_free) begin
      if (skid_vld_r) begin
        main_vld_r <= 1'b1;
        skid_vld_r <= 1'b0;
      end else begin
        main_vld_r <= push;
      end
    end else if (push) begin
      skid_vld_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (main_free) begin
      main_r <= skid_vld_r ? skid_r : push_data;
    end
    // park the new result while the main register is held
    if (!main_free && push) begin
      skid_r <= push_data;
    end
  end

  assign full      = skid_vld_r;
  assign out_valid = main_vld_r;
  assign out_data  = main_r;

endmodule

// ===== hw/rtl/bad_checker.sv =====
// Port-level checks for base_attach_detector_core, bound to the top level.
// Depends on bad_pkg for the payload structs.
module bad_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input bad_pkg::bad_out_t out_data
);
  import bad_pkg::*;

  // slate mode mirrors the attach state
  a_slate_inv: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.slate_mode == !out_data.base_attached))
    else $error("slate_mode does not mirror base_attached");

  // the switch is only on while attached
  a_lp_attached: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.low_power_switch |-> out_data.base_attached)
    else $error("low-power switch on while detached");

  // backpressure only builds up behind a stalled result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(in_stall) |-> $past(out_valid && out_stall && in_valid))
    else $error("in_stall rose without a stalled result");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

endmodule

bind base_attach_detector_core bad_checker u_bad_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

// ===== bench/base_attach_detector_core_tb.sv =====
`timescale 1ns / 1ps
// Testbench for base_attach_detector_core: random and directed requests checked
// against a built-in state predictor. Depends on bad_pkg and the core RTL only.
module base_attach_detector_core_tb;
  import bad_pkg::*;

  localparam int MV_MAX      = (1 << MV_W) - 1;
  localparam int TENTHS_MAX  = 1000;
  localparam int HOLD_CYCLES = 60;
  localparam int LIMIT_NS    = 2_000_000;

  class attach_scoreboard;
    logic [MV_W-1:0]  thr_normal = 12'd2500;
    logic [MV_W-1:0]  thr_low    = 12'd1000;
    logic [PCT_W-1:0] bat_limit  = 7'd10;
    logic [DLY_W-1:0] interval   = 10'd30;
    logic [DLY_W-1:0] att_deb    = 10'd300;
    logic [DLY_W-1:0] det_deb    = 10'd0;

    bit   attached   = 1'b0;
    bit   debouncing = 1'b0;
    bit   detect_en  = 1'b1;
    bit   lowpwr     = 1'b0;
    cnt_t countdown  = '0;

    bad_out_t expected_status[$];
    int errors, n_requests, n_ticks, n_changes, n_switch_on;

    function cnt_t to_count(logic [DLY_W-1:0] d);
      int c;
      c = (d == '0) ? 0 : int'(d) - 1;
      if (c > CNT_MAX) begin
        c = CNT_MAX;
      end
      return cnt_t'(c);
    endfunction

    function void set_switch(logic [TEN_W-1:0] tenths, bit ext);
      int pct;
      pct = (int'(tenths) + 5) / 10;
      if (!attached || debouncing) begin
        lowpwr = 1'b0;
      end else begin
        lowpwr = (pct < int'(bat_limit)) && !ext;
      end
    endfunction

    function void go_enable();
      countdown = to_count(interval);
      detect_en = 1'b1;
    endfunction

    function void go_disable(logic [TEN_W-1:0] tenths, bit ext);
      detect_en = 1'b0;
      attached  = 1'b0;
      set_switch(tenths, ext);
    endfunction

    function void set_reg(reg_idx_t idx, logic [CFG_W-1:0] v);
      case (idx)
        REG_THR_NORMAL: thr_normal = v[MV_W-1:0];
        REG_THR_LOW:    thr_low    = v[MV_W-1:0];
        REG_BAT_LIMIT:  bat_limit  = v[PCT_W-1:0];
        REG_INTERVAL:   interval   = v[DLY_W-1:0];
        REG_ATT_DEB:    att_deb    = v[DLY_W-1:0];
        REG_DET_DEB:    det_deb    = v[DLY_W-1:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return expected_status.size();
    endfunction

    function void predict_request(bad_in_t r);
      bit               was, above;
      logic [MV_W-1:0]  th;
      logic [DLY_W-1:0] nxt;
      bad_out_t         e;
      was = attached;
      n_requests++;
      case (req_type_t'(r.req_type))
        REQ_TICK: begin
          n_ticks++;
          if (detect_en) begin
            if (countdown != '0) begin
              countdown--;
            end else begin
              th    = lowpwr ? thr_low : thr_normal;
              nxt   = interval;
              above = r.sense_mv > th;
              // a sample that disagrees with the state either starts or confirms debounce
              if (above == attached) begin
                if (!debouncing) begin
                  debouncing = 1'b1;
                  nxt = above ? det_deb : att_deb;
                end else begin
                  debouncing = 1'b0;
                  attached   = !above;
                  set_switch(r.battery_tenths, r.ac_present);
                end
              end else begin
                debouncing = 1'b0;
              end
              countdown = to_count(nxt);
            end
          end
        end
        REQ_AC: begin
          if (r.chipset_off) begin
            if (r.ac_present) begin
              go_enable();
            end else begin
              go_disable(r.battery_tenths, r.ac_present);
            end
          end
          set_switch(r.battery_tenths, r.ac_present);
        end
        REQ_BATTERY: set_switch(r.battery_tenths, r.ac_present);
        REQ_STARTUP: begin
          go_enable();
          if (attached) begin
            set_switch(r.battery_tenths, r.ac_present);
          end
        end
        REQ_SHUTDOWN: begin
          if (!r.ac_present) begin
            go_disable(r.battery_tenths, r.ac_present);
          end
        end
        REQ_F_ATTACH: begin
          go_disable(r.battery_tenths, r.ac_present);
          attached = 1'b1;
          set_switch(r.battery_tenths, r.ac_present);
        end
        REQ_F_DETACH: begin
          go_disable(r.battery_tenths, r.ac_present);
          attached = 1'b0;
          set_switch(r.battery_tenths, r.ac_present);
        end
        default: go_enable();
      endcase
      e.base_attached    = attached;
      e.slate_mode       = !attached;
      e.low_power_switch = lowpwr;
      e.state_changed    = (was != attached);
      e.detecting        = detect_en;
      expected_status.push_back(e);
    endfunction

    function void compare_bit(string name, logic exp, logic act);
      if (act !== exp) begin
        $error("%s mismatch: expected %0b, actual %0b", name, exp, act);
        errors++;
      end
    endfunction

    function void check_status(bad_out_t got);
      bad_out_t e;
      if (expected_status.size() == 0) begin
        $error("result %b arrived with no request outstanding", got);
        errors++;
        return;
      end
      e = expected_status.pop_front();
      compare_bit("base_attached", e.base_attached, got.base_attached);
      compare_bit("slate_mode", e.slate_mode, got.slate_mode);
      compare_bit("low_power_switch", e.low_power_switch, got.low_power_switch);
      compare_bit("state_changed", e.state_changed, got.state_changed);
      compare_bit("detecting", e.detecting, got.detecting);
      if (e.state_changed) n_changes++;
      if (e.low_power_switch) n_switch_on++;
    endfunction
  endclass

  logic             clk = 1'b0;
  logic             rst_n;
  logic             in_valid;
  logic             in_stall;
  bad_in_t          in_data;
  logic             out_valid;
  logic             out_stall;
  bad_out_t         out_data;
  logic             cfg_we;
  logic [IDX_W-1:0] cfg_idx;
  logic [CFG_W-1:0] cfg_wdata;

  attach_scoreboard sb;
  bit quiet = 1'b0;
  int hold_off_cycles = 0;
  bit level_high = 1'b0;
  int n_settings = 0;

  base_attach_detector_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n === 1'b1) begin
      if (out_valid && !out_stall) sb.check_status(out_data);
      if (in_valid && !in_stall) sb.predict_request(in_data);
    end
  end

  // Receiver: random stalls (none while quiet) and a counted hold-off on demand.
  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_cycles > 0) begin
        out_stall <= 1'b1;
        hold_off_cycles--;
      end else begin
        out_stall <= !quiet && ($urandom_range(0, 99) < 23);
      end
    end
  end

  initial begin
    #(LIMIT_NS);
    $display("timeout with %0d results outstanding", sb.pending());
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic bad_in_t req_item(req_type_t t, int mv, int tenths, bit ext, bit off);
    bad_in_t r;
    r.req_type       = t;
    r.sense_mv       = MV_W'(mv);
    r.battery_tenths = TEN_W'(tenths);
    r.ac_present     = ext;
    r.chipset_off    = off;
    return r;
  endfunction

  function automatic bad_cfg_t make_cfg(int thn, int thl, int lim, int ivl, int att, int det);
    bad_cfg_t c;
    c.threshold_normal_mv   = MV_W'(thn);
    c.threshold_low_mv      = MV_W'(thl);
    c.battery_limit_pct     = PCT_W'(lim);
    c.sample_interval_ticks = DLY_W'(ivl);
    c.attach_debounce_ticks = DLY_W'(att);
    c.detach_debounce_ticks = DLY_W'(det);
    return c;
  endfunction

  // Mostly ticks whose voltage holds one side of a threshold for a while,
  // so debounce confirmations happen; the rest are power and forced events.
  function automatic bad_in_t make_request();
    bad_in_t r;
    int roll, th, lim;
    roll = $urandom_range(0, 99);
    if (roll < 75)      r.req_type = REQ_TICK;
    else if (roll < 79) r.req_type = REQ_AC;
    else if (roll < 83) r.req_type = REQ_BATTERY;
    else if (roll < 88) r.req_type = REQ_STARTUP;
    else if (roll < 92) r.req_type = REQ_RESUME;
    else if (roll < 95) r.req_type = REQ_SHUTDOWN;
    else if (roll < 98) r.req_type = REQ_F_ATTACH;
    else                r.req_type = REQ_F_DETACH;
    if (r.req_type == REQ_TICK && !sb.detect_en && $urandom_range(0, 3) == 0) begin
      r.req_type = REQ_RESUME;
    end
    if ($urandom_range(0, 11) == 0) level_high = !level_high;
    th = $urandom_range(0, 1) ? int'(sb.thr_low) : int'(sb.thr_normal);
    if ($urandom_range(0, 9) == 0) begin
      r.sense_mv = MV_W'($urandom_range(0, MV_MAX));
    end else if (level_high) begin
      r.sense_mv = (th >= MV_MAX) ? MV_W'(MV_MAX) : MV_W'($urandom_range(th + 1, MV_MAX));
    end else begin
      r.sense_mv = MV_W'($urandom_range(0, th));
    end
    lim = int'(sb.bat_limit) * 10;
    if ($urandom_range(0, 1)) begin
      r.battery_tenths = TEN_W'($urandom_range(0, TENTHS_MAX));
    end else begin
      r.battery_tenths = TEN_W'($urandom_range((lim < 12) ? 0 : lim - 12,
                                 (lim + 12 > TENTHS_MAX) ? TENTHS_MAX : lim + 12));
    end
    r.ac_present  = 1'($urandom_range(0, 1));
    r.chipset_off = 1'($urandom_range(0, 1));
    return r;
  endfunction

  task automatic send_request(bad_in_t r);
    in_valid <= 1'b1;
    in_data  <= r;
    do @(posedge clk); while (in_stall);
    if (!quiet && $urandom_range(0, 99) < 30) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  // Hold requests until every outstanding result has been taken.
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
    repeat (2) @(posedge clk);
  endtask

  task automatic put_reg(reg_idx_t idx, logic [CFG_W-1:0] v);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    sb.set_reg(idx, v);
  endtask

  task automatic apply_config(bad_cfg_t c);
    put_reg(REG_THR_NORMAL, c.threshold_normal_mv);
    put_reg(REG_THR_LOW, c.threshold_low_mv);
    put_reg(REG_BAT_LIMIT, CFG_W'(c.battery_limit_pct));
    put_reg(REG_INTERVAL, CFG_W'(c.sample_interval_ticks));
    put_reg(REG_ATT_DEB, CFG_W'(c.attach_debounce_ticks));
    put_reg(REG_DET_DEB, CFG_W'(c.detach_debounce_ticks));
    cfg_we <= 1'b0;
    n_settings++;
  endtask

  task automatic run_phase(bad_cfg_t c, int n, bit no_idle, int hold_at);
    drain();
    apply_config(c);
    quiet = no_idle;
    for (int i = 0; i < n; i++) begin
      if (i == hold_at) hold_off_cycles = HOLD_CYCLES;
      send_request(make_request());
    end
  endtask

  initial begin
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_we    <= 1'b0;
    cfg_idx   <= '0;
    cfg_wdata <= '0;
    rst_n     <= 1'b0;
    sb = new();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: first tick samples at once, threshold equality counts as attached
    send_request(req_item(REQ_TICK, 2500, 500, 1'b0, 1'b0));
    send_request(req_item(REQ_TICK, MV_MAX, 500, 1'b0, 1'b0));
    send_request(req_item(REQ_TICK, 0, 500, 1'b1, 1'b1));
    send_request(req_item(REQ_AC, 0, TENTHS_MAX, 1'b1, 1'b0));
    send_request(req_item(REQ_F_ATTACH, 0, 0, 1'b0, 1'b0));
    send_request(req_item(REQ_TICK, 0, 0, 1'b0, 1'b0));
    send_request(req_item(REQ_STARTUP, 0, 94, 1'b0, 1'b1));
    send_request(req_item(REQ_BATTERY, 0, TENTHS_MAX, 1'b1, 1'b0));
    send_request(req_item(REQ_F_DETACH, 0, 999, 1'b0, 1'b0));

    // zero delays: sample on every tick
    drain();
    apply_config(make_cfg(2500, 1000, 10, 0, 0, 0));
    send_request(req_item(REQ_RESUME, 0, 0, 1'b0, 1'b0));
    send_request(req_item(REQ_TICK, 0, 0, 1'b0, 1'b0));
    send_request(req_item(REQ_TICK, 0, 0, 1'b0, 1'b0));
    send_request(req_item(REQ_BATTERY, 0, 94, 1'b0, 1'b0));
    send_request(req_item(REQ_BATTERY, 0, 95, 1'b0, 1'b0));
    send_request(req_item(REQ_BATTERY, 0, 94, 1'b1, 1'b0));
    send_request(req_item(REQ_BATTERY, 0, 0, 1'b0, 1'b0));
    send_request(req_item(REQ_TICK, 1001, 0, 1'b0, 1'b0));
    send_request(req_item(REQ_TICK, 1000, 0, 1'b0, 1'b0));
    send_request(req_item(REQ_TICK, MV_MAX, 0, 1'b0, 1'b0));
    send_request(req_item(REQ_TICK, MV_MAX, 0, 1'b0, 1'b0));
    send_request(req_item(REQ_STARTUP, 0, 500, 1'b0, 1'b0));
    send_request(req_item(REQ_AC, 0, 500, 1'b1, 1'b1));
    send_request(req_item(REQ_AC, 0, 500, 1'b0, 1'b1));
    send_request(req_item(REQ_SHUTDOWN, 0, 500, 1'b1, 1'b0));
    send_request(req_item(REQ_SHUTDOWN, 0, 500, 1'b0, 1'b0));
    send_request(req_item(REQ_RESUME, MV_MAX, TENTHS_MAX, 1'b1, 1'b1));

    run_phase(make_cfg(2000, 1500, 50, 2, 3, 0), 80, 1'b0, 20);
    run_phase(make_cfg(0, MV_MAX, 100, 0, 0, 0), 60, 1'b0, 30);
    for (int p = 0; p < 5; p++) begin
      run_phase(make_cfg($urandom_range(0, MV_MAX), $urandom_range(0, MV_MAX),
                         $urandom_range(0, 100), $urandom_range(0, 4),
                         $urandom_range(0, 6), $urandom_range(0, 6)),
                52, p == 2, -1);
    end
    // longest delays last, so their countdowns do not starve later settings
    run_phase(make_cfg(MV_MAX, 0, 0, 1023, 1023, 1023), 25, 1'b0, -1);
    drain();
    repeat (4) @(posedge clk);

    $display("Covered %0d requests (%0d ticks) across %0d register settings,",
             sb.n_requests, sb.n_ticks, n_settings);
    $display("  with %0d attach-state changes and %0d results with the switch on",
             sb.n_changes, sb.n_switch_on);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
